FILE: design/at_response_line_classifier_macros.svh
// Assertion macros for the AT response line classifier.
// Included by the top level; relies on the ports clock and reset being in scope.
`ifndef AT_RESPONSE_LINE_CLASSIFIER_MACROS_SVH
`define AT_RESPONSE_LINE_CLASSIFIER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ATRLC_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("atrlc same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define ATRLC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("atrlc next-cycle check failed");

`endif

FILE: design/atrlc_pkg.sv
// Shared types and constants of the AT response line classifier.
// Holds the pattern texts and lengths, character codes and flag bit positions.
package atrlc_pkg;

   typedef logic [7:0] byte_type;

   localparam int NUM_PAT   = 13;
   localparam int WIN_DEPTH = 17;
   localparam int PAT_BYTES = WIN_DEPTH + 1;

   typedef logic [8*PAT_BYTES-1:0] pat_text_type;
   typedef logic [4:0]             pat_len_type;
   typedef logic [NUM_PAT-1:0]     hit_type;

   // Texts are right-aligned: the last character sits in bits [7:0].
   localparam pat_text_type PAT_TEXT [NUM_PAT] = '{
      "+CME ERROR:", "+CIPRCV:", "OK", "Waiting ...", "+CIEV: READY",
      "+CME ERROR:50", "+CME ERROR:148", "+CME ERROR:58",
      "+CIEV: service,  1", "CONNECT OK", "+CCID:", "+CSQ:", "+CGATT:1"
   };
   localparam pat_len_type PAT_LEN [NUM_PAT] = '{
      5'd11, 5'd8, 5'd2, 5'd11, 5'd12, 5'd13, 5'd14, 5'd13, 5'd18, 5'd10, 5'd6, 5'd5, 5'd8
   };

   localparam int PAT_CME_ERROR  = 0;
   localparam int PAT_CIPRCV     = 1;
   localparam int PAT_OK         = 2;
   localparam int PAT_WAITING    = 3;
   localparam int PAT_CIEV_READY = 4;
   localparam int PAT_CME_50     = 5;
   localparam int PAT_CME_148    = 6;
   localparam int PAT_CME_58     = 7;
   localparam int PAT_CIEV_SVC   = 8;
   localparam int PAT_CONNECT_OK = 9;
   localparam int PAT_CCID       = 10;
   localparam int PAT_CSQ        = 11;
   localparam int PAT_CGATT      = 12;

   localparam int FLAG_ERROR   = 1;
   localparam int FLAG_RECEIVE = 2;
   localparam int FLAG_PROMPT  = 3;
   localparam int FLAG_OK      = 4;
   localparam int FLAG_WAITING = 5;
   localparam int FLAG_READY   = 6;
   localparam int FLAG_CONNECT = 7;
   localparam int FLAG_SERVICE = 8;
   localparam int FLAG_NO_SIM  = 9;

   localparam logic OP_RX_BYTE   = 1'b0;
   localparam logic OP_OVERWRITE = 1'b1;

   localparam byte_type CHAR_NUL   = 8'h00;
   localparam byte_type CHAR_NL    = 8'h0A;
   localparam byte_type CHAR_GT    = 8'h3E;
   localparam byte_type CHAR_DIGIT = 8'h30;
   localparam byte_type TEN        = 8'd10;

   localparam logic [7:0] COUNT_MAX   = 8'd255;
   localparam logic [7:0] INDEX_SIX   = 8'd6;
   localparam logic [7:0] INDEX_SEVEN = 8'd7;

   typedef struct packed {
      logic shift;
      logic clear;
   } win_ctrl_type;

endpackage

FILE: design/at_response_line_classifier.sv
// AT response line classifier top level: a row of window cells, the matcher and line state.
// An accepted input beat has its result beat in the output register in the next cycle.
// Throughput: one beat per cycle while not stalled; cells shift on rx bytes before a NUL.
// The input is ready whenever the output register is empty or being drained.
// Synchronous reset clears all line state, sets flags to 1 and empties the output register.
// Depends on atrlc_pkg, atrlc_window_cell, atrlc_matcher and the macros header.
`include "at_response_line_classifier_macros.svh"

module at_response_line_classifier
   import atrlc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_op,
   input  logic [7:0] req_rx_byte,
   input  logic [9:0] req_flags_value,
   input  logic [1:0] req_icon_value,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_echo_byte,
   output logic       rsp_line_end,
   output logic [9:0] rsp_flags,
   output logic [1:0] rsp_icon,
   output logic [7:0] rsp_signal_quality
);

   logic         accept;
   logic         rx_beat;
   logic         line_done;
   win_ctrl_type win_ctrl;
   byte_type     win [WIN_DEPTH];
   hit_type      hits;

   hit_type      found_ff, found_in, hit_all;
   logic         nul_seen_ff, nul_seen_in;
   logic         first_nul_ff, first_nul_in;
   logic [7:0]   line_count_ff, line_count_in, count_inc;
   byte_type     byte6_ff, byte6_in;
   byte_type     byte7_ff, byte7_in;
   logic [9:0]   flags_ff, flags_in;
   logic [1:0]   icon_ff, icon_in;
   byte_type     quality_ff, quality_in;
   logic         icon7_set, icon7_clr;

   logic         rsp_valid_ff, rsp_valid_in;
   byte_type     rsp_echo_ff, rsp_echo_in;
   logic         rsp_end_ff, rsp_end_in;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rx_beat   = accept && (req_op == OP_RX_BYTE);
   assign line_done = rx_beat && (req_rx_byte == CHAR_NL);

   assign win_ctrl.shift = rx_beat && !nul_seen_ff && (req_rx_byte != CHAR_NUL);
   assign win_ctrl.clear = line_done;

   for (genvar i = 0; i < WIN_DEPTH; i++) begin : g_cell
      atrlc_window_cell u_cell (
         .clock (clock),
         .reset (reset),
         .ctrl  (win_ctrl),
         .d_in  ((i == 0) ? req_rx_byte : win[(i == 0) ? 0 : i-1]),
         .q     (win[i])
      );
   end

   atrlc_matcher u_matcher (
      .cur  (req_rx_byte),
      .win  (win),
      .hits (hits)
   );

   assign count_inc = (line_count_ff == COUNT_MAX) ? line_count_ff : line_count_ff + 8'd1;
   assign hit_all   = win_ctrl.shift ? (found_ff | hits) : found_ff;

   always_comb begin
      found_in      = found_ff;
      nul_seen_in   = nul_seen_ff;
      first_nul_in  = first_nul_ff;
      line_count_in = line_count_ff;
      byte6_in      = byte6_ff;
      byte7_in      = byte7_ff;
      flags_in      = flags_ff;
      icon_in       = icon_ff;
      quality_in    = quality_ff;
      icon7_set     = 1'b0;
      icon7_clr     = 1'b0;
      if (accept && (req_op == OP_OVERWRITE)) begin
         flags_in = req_flags_value;
         icon_in  = req_icon_value;
      end else if (rx_beat) begin
         if (line_count_ff == 8'd0) begin
            if (req_rx_byte == CHAR_GT) begin
               flags_in[FLAG_PROMPT] = 1'b1;
            end
            first_nul_in = (req_rx_byte == CHAR_NUL);
         end
         if (line_count_ff == INDEX_SIX) begin
            byte6_in = req_rx_byte;
         end
         if (line_count_ff == INDEX_SEVEN) begin
            byte7_in = req_rx_byte;
         end
         if (!nul_seen_ff && (req_rx_byte == CHAR_NUL)) begin
            nul_seen_in = 1'b1;
         end
         found_in      = hit_all;
         line_count_in = count_inc;
         if (line_done) begin
            if (count_inc == INDEX_SIX) begin
               byte6_in = CHAR_NUL;
            end
            if (count_inc == INDEX_SEVEN) begin
               byte7_in = CHAR_NUL;
            end
            flags_in[FLAG_ERROR]   = flags_in[FLAG_ERROR] | hit_all[PAT_CME_ERROR];
            flags_in[FLAG_RECEIVE] = flags_in[FLAG_RECEIVE] | hit_all[PAT_CIPRCV];
            flags_in[FLAG_OK]      = flags_in[FLAG_OK] | hit_all[PAT_OK];
            flags_in[FLAG_WAITING] = flags_in[FLAG_WAITING] | first_nul_in
                                     | hit_all[PAT_WAITING];
            flags_in[FLAG_READY]   = flags_in[FLAG_READY] | hit_all[PAT_CIEV_READY];
            flags_in[FLAG_NO_SIM]  = flags_in[FLAG_NO_SIM] | hit_all[PAT_CME_58];
            flags_in[FLAG_SERVICE] = flags_in[FLAG_SERVICE] | hit_all[PAT_CIEV_SVC];
            flags_in[FLAG_CONNECT] = flags_in[FLAG_CONNECT] | hit_all[PAT_CIEV_SVC]
                                     | hit_all[PAT_CONNECT_OK];
            icon7_clr = first_nul_in | hit_all[PAT_WAITING]
                        | (hit_all[PAT_CIEV_READY] & !flags_ff[FLAG_SERVICE])
                        | hit_all[PAT_CME_50] | hit_all[PAT_CME_148] | hit_all[PAT_CME_58];
            icon7_set = hit_all[PAT_CIEV_SVC] | hit_all[PAT_CONNECT_OK] | hit_all[PAT_CGATT];
            if (icon7_set) begin
               icon_in[1] = 1'b1;
            end else if (icon7_clr) begin
               icon_in[1] = 1'b0;
            end
            icon_in[0] = icon_ff[0] | hit_all[PAT_CCID];
            if (hit_all[PAT_CSQ]) begin
               quality_in = (byte6_in - CHAR_DIGIT) * TEN + byte7_in - CHAR_DIGIT;
            end
            found_in      = '0;
            nul_seen_in   = 1'b0;
            line_count_in = 8'd0;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_echo_in  = rsp_echo_ff;
      rsp_end_in   = rsp_end_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_echo_in  = rx_beat ? req_rx_byte : CHAR_NUL;
         rsp_end_in   = line_done;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff      <= '0;
         nul_seen_ff   <= 1'b0;
         first_nul_ff  <= 1'b0;
         line_count_ff <= 8'd0;
         byte6_ff      <= CHAR_NUL;
         byte7_ff      <= CHAR_NUL;
         flags_ff      <= 10'd1;
         icon_ff       <= 2'd0;
         quality_ff    <= 8'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         found_ff      <= found_in;
         nul_seen_ff   <= nul_seen_in;
         first_nul_ff  <= first_nul_in;
         line_count_ff <= line_count_in;
         byte6_ff      <= byte6_in;
         byte7_ff      <= byte7_in;
         flags_ff      <= flags_in;
         icon_ff       <= icon_in;
         quality_ff    <= quality_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_echo_ff <= rsp_echo_in;
      rsp_end_ff  <= rsp_end_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_echo_byte      = rsp_echo_ff;
   assign rsp_line_end       = rsp_end_ff;
   assign rsp_flags          = flags_ff;
   assign rsp_icon           = icon_ff;
   assign rsp_signal_quality = quality_ff;

   `ATRLC_ASSERT_NEXT(a_line_restart, line_done, (line_count_ff == 8'd0) && (found_ff == '0) && !nul_seen_ff)
   `ATRLC_ASSERT_SAME(a_no_shift_after_nul, nul_seen_ff, !win_ctrl.shift)
   `ATRLC_ASSERT_SAME(a_end_is_newline, rsp_valid_ff && rsp_end_ff, rsp_echo_ff == CHAR_NL)

endmodule

FILE: design/atrlc_window_cell.sv
// One cell of the line history window: holds one byte and passes it on.
// Depends on atrlc_pkg for the byte and control types.
module atrlc_window_cell
   import atrlc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  win_ctrl_type ctrl,
   input  byte_type     d_in,
   output byte_type     q
);

   byte_type data_ff;
   byte_type data_in;

   always_comb begin
      data_in = data_ff;
      if (ctrl.clear) begin
         data_in = CHAR_NUL;
      end else if (ctrl.shift) begin
         data_in = d_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff <= CHAR_NUL;
      end else begin
         data_ff <= data_in;
      end
   end

   assign q = data_ff;

endmodule

FILE: design/atrlc_matcher.sv
// Compares the current byte and the history window with every pattern.
// Depends on atrlc_pkg for the pattern texts and lengths.
module atrlc_matcher
   import atrlc_pkg::*;
(
   input  byte_type cur,
   input  byte_type win [WIN_DEPTH],
   output hit_type  hits
);

   always_comb begin
      byte_type sym [PAT_BYTES];
      sym[0] = cur;
      for (int k = 1; k < PAT_BYTES; k++) begin
         sym[k] = win[k-1];
      end
      for (int p = 0; p < NUM_PAT; p++) begin
         hits[p] = 1'b1;
         for (int k = 0; k < PAT_BYTES; k++) begin
            if ((k < int'(PAT_LEN[p])) && (sym[k] != PAT_TEXT[p][8*k +: 8])) begin
               hits[p] = 1'b0;
            end
         end
      end
   end

endmodule
